/* src/tfn_pkg.sv */
// Shared types, constants and tables for the tetrahedron face normal block.
package tfn_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 30;
  localparam int CNT_W          = 16;
  localparam int FACES          = 4;
  localparam int NORM_TOP       = 62;

  // vertex indices of the edges of each face: a = v[EA0]-v[EA1], b = v[EB0]-v[EB1]
  localparam logic [1:0] EA0 [FACES] = '{2'd1, 2'd2, 2'd3, 2'd2};
  localparam logic [1:0] EA1 [FACES] = '{2'd0, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] EB0 [FACES] = '{2'd2, 2'd3, 2'd1, 2'd1};
  localparam logic [1:0] EB1 [FACES] = '{2'd0, 2'd0, 2'd0, 2'd3};

  // cross product terms, even terms add, odd terms subtract, component = term / 2
  localparam logic [1:0] TERM_A [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam logic [1:0] TERM_B [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};

  typedef enum logic [3:0] {
    L_IDLE,
    L_CROSS,
    L_XEND,
    L_ABS,
    L_NORM,
    L_SQ,
    L_SEND,
    L_SQRT,
    L_DIVI,
    L_DIV,
    L_FIN,
    L_DONE
  } lane_st_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic degen;
  } lane_stat_t;

endpackage

/* src/tfn_if.sv */
// Request channel interfaces: vertex input, face result output, configuration write.
interface tfn_in_if import tfn_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] node0_x, node0_y, node0_z;
  logic signed [COORD_BITS-1:0] node1_x, node1_y, node1_z;
  logic signed [COORD_BITS-1:0] node2_x, node2_y, node2_z;
  logic signed [COORD_BITS-1:0] node3_x, node3_y, node3_z;
  modport source (output valid, node0_x, node0_y, node0_z, node1_x, node1_y, node1_z,
                  node2_x, node2_y, node2_z, node3_x, node3_y, node3_z, input ready);
  modport sink (input valid, node0_x, node0_y, node0_z, node1_x, node1_y, node1_z,
                node2_x, node2_y, node2_z, node3_x, node3_y, node3_z, output ready);
endinterface

interface tfn_out_if import tfn_pkg::*; #(parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF);
  logic valid;
  logic ready;
  logic [1:0] face_index;
  logic signed [NORMAL_FRAC_BITS+1:0] normal_x, normal_y, normal_z;
  logic degenerate;
  logic last_face;
  logic batch_end;
  modport source (output valid, face_index, normal_x, normal_y, normal_z, degenerate,
                  last_face, batch_end, input ready);
  modport sink (input valid, face_index, normal_x, normal_y, normal_z, degenerate,
                last_face, batch_end, output ready);
endinterface

interface tfn_cfg_if import tfn_pkg::*;;
  logic valid;
  logic ready;
  logic [CNT_W-1:0] element_count;
  modport source (output valid, element_count, input ready);
  modport sink (input valid, element_count, output ready);
endinterface

/* src/tfn_lane.sv */
// One face lane: cross product, normalize, sum of squares, square root, divide.
module tfn_lane import tfn_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          ack,
  input  logic signed [COORD_BITS:0]    edge_a [3],
  input  logic signed [COORD_BITS:0]    edge_b [3],
  output lane_stat_t                    stat,
  output logic [NORMAL_FRAC_BITS+1:0]   norm [3]
);

  localparam int DW  = COORD_BITS + 1;
  localparam int CW  = 2 * DW + 1;
  localparam int MW  = CW - 1;
  localparam int NRW = (MW > NORM_TOP + 1) ? MW : NORM_TOP + 1;
  localparam int QW  = NORMAL_FRAC_BITS + 1;
  localparam int OW  = NORMAL_FRAC_BITS + 2;
  localparam int DCW = (QW > 2) ? $clog2(QW) : 1;

  lane_st_t st_r, st_nxt;

  logic signed [DW-1:0] a_r [3];
  logic signed [DW-1:0] b_r [3];
  logic [2:0]   t_r;
  logic [1:0]   p_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_sh_r;
  logic         pp_neg_r;
  logic [1:0]   pp_k_r;
  logic         pp_v_r;
  logic         pp_sum_r;
  logic [CW-1:0]  c_r [3];
  logic [NRW-1:0] m_r [3];
  logic [2:0]   neg_r;
  logic [127:0] s_r;
  logic [65:0]  rem_r;
  logic [63:0]  root_r;
  logic [5:0]   it_r;
  logic [64:0]  dr_r [3];
  logic [QW-1:0] q_r [3];
  logic [DCW-1:0] di_r;
  logic         degen_r;
  logic [OW-1:0] norm_r [3];

  logic signed [DW-1:0] opa, opb;
  logic [DW-1:0]  mag_a, mag_b;
  logic [63:0]    ma, mb;
  logic [31:0]    mx, my;
  logic           op_neg;
  logic [127:0]   sh128;
  logic [CW-1:0]  add_c;
  logic [NRW-1:0] orv;
  logic [67:0]    sq_tmp, sq_trial;
  logic [65:0]    dv_d;
  logic [65:0]    dv_tmp [3];

  always_comb begin
    opa    = a_r[TERM_A[t_r]];
    opb    = b_r[TERM_B[t_r]];
    mag_a  = opa[DW-1] ? DW'(-opa) : DW'(opa);
    mag_b  = opb[DW-1] ? DW'(-opb) : DW'(opb);
    if (st_r == L_SQ) begin
      ma     = 64'(m_r[t_r[1:0]][NORM_TOP:0]);
      mb     = ma;
      op_neg = 1'b0;
    end else begin
      ma     = 64'(mag_a);
      mb     = 64'(mag_b);
      op_neg = opa[DW-1] ^ opb[DW-1] ^ t_r[0];
    end
    mx = ma[32*p_r[1] +: 32];
    my = mb[32*p_r[0] +: 32];
  end

  assign sh128    = {64'd0, pp_r} << {pp_sh_r, 5'd0};
  assign add_c    = sh128[CW-1:0];
  assign orv      = m_r[0] | m_r[1] | m_r[2];
  assign sq_tmp   = {rem_r, s_r[127:126]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign dv_d     = {1'b0, root_r, 1'b0};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_tmp[k] = {dr_r[k], root_r[6'(di_r)]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      L_IDLE:  if (start) st_nxt = L_CROSS;
      L_CROSS: if (t_r == 3'd5 && p_r == 2'd3) st_nxt = L_XEND;
      L_XEND:  st_nxt = L_ABS;
      L_ABS:   st_nxt = L_NORM;
      L_NORM: begin
        priority if (orv == '0) st_nxt = L_DONE;
        else if (orv >> (NORM_TOP + 1) != '0) st_nxt = L_NORM;
        else if (orv[NORM_TOP -: 8] == 8'd0 || !orv[NORM_TOP]) st_nxt = L_NORM;
        else st_nxt = L_SQ;
      end
      L_SQ:    if (t_r == 3'd2 && p_r == 2'd3) st_nxt = L_SEND;
      L_SEND:  st_nxt = L_SQRT;
      L_SQRT:  if (it_r == 6'd63) st_nxt = L_DIVI;
      L_DIVI:  st_nxt = L_DIV;
      L_DIV:   if (di_r == '0) st_nxt = L_FIN;
      L_FIN:   st_nxt = L_DONE;
      L_DONE:  if (ack) st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else begin
      pp_v_r <= (st_r == L_CROSS) || (st_r == L_SQ);
    end
  end

  always_ff @(posedge clk) begin
    pp_r     <= 64'(mx) * 64'(my);
    pp_sh_r  <= 2'(p_r[1]) + 2'(p_r[0]);
    pp_neg_r <= op_neg;
    pp_k_r   <= (st_r == L_SQ) ? t_r[1:0] : t_r[2:1];
    pp_sum_r <= (st_r == L_SQ);
    if (pp_v_r) begin
      if (pp_sum_r) begin
        s_r <= s_r + sh128;
      end else begin
        c_r[pp_k_r] <= pp_neg_r ? c_r[pp_k_r] - add_c : c_r[pp_k_r] + add_c;
      end
    end
    unique case (st_r)
      L_IDLE: begin
        if (start) begin
          a_r     <= edge_a;
          b_r     <= edge_b;
          t_r     <= '0;
          p_r     <= '0;
          degen_r <= 1'b0;
          for (int k = 0; k < 3; k++) c_r[k] <= '0;
        end
      end
      L_CROSS, L_SQ: begin
        p_r <= p_r + 2'd1;
        if (p_r == 2'd3) t_r <= t_r + 3'd1;
      end
      L_XEND, L_DONE: begin
      end
      L_ABS: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= c_r[k][CW-1];
          m_r[k]   <= NRW'(c_r[k][CW-1] ? MW'(~c_r[k] + 1'b1) : c_r[k][MW-1:0]);
        end
      end
      L_NORM: begin
        t_r <= '0;
        p_r <= '0;
        s_r <= '0;
        priority if (orv == '0) begin
          degen_r <= 1'b1;
          for (int k = 0; k < 3; k++) norm_r[k] <= '0;
        end else if (orv >> (NORM_TOP + 9) != '0) begin
          for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] >> 8;
        end else if (orv >> (NORM_TOP + 1) != '0) begin
          for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] >> 1;
        end else if (orv[NORM_TOP -: 8] == 8'd0) begin
          for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] << 8;
        end else if (!orv[NORM_TOP]) begin
          for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] << 1;
        end else begin
        end
      end
      L_SEND: begin
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
      end
      L_SQRT: begin
        it_r <= it_r + 6'd1;
        s_r  <= s_r << 2;
        if (sq_tmp >= sq_trial) begin
          rem_r  <= 66'(sq_tmp - sq_trial);
          root_r <= {root_r[62:0], 1'b1};
        end else begin
          rem_r  <= sq_tmp[65:0];
          root_r <= {root_r[62:0], 1'b0};
        end
      end
      L_DIVI: begin
        di_r <= DCW'(QW - 1);
        for (int k = 0; k < 3; k++) begin
          dr_r[k] <= 65'(m_r[k][NORM_TOP:0]) + 65'(root_r >> QW);
          q_r[k]  <= '0;
        end
      end
      L_DIV: begin
        di_r <= di_r - 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (dv_tmp[k] >= dv_d) begin
            dr_r[k] <= 65'(dv_tmp[k] - dv_d);
            q_r[k]  <= {q_r[k][QW-2:0], 1'b1};
          end else begin
            dr_r[k] <= dv_tmp[k][64:0];
            q_r[k]  <= {q_r[k][QW-2:0], 1'b0};
          end
        end
      end
      L_FIN: begin
        for (int k = 0; k < 3; k++) begin
          norm_r[k] <= neg_r[k] ? OW'(~OW'(q_r[k]) + 1'b1) : OW'(q_r[k]);
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.idle  = (st_r == L_IDLE);
  assign stat.done  = (st_r == L_DONE);
  assign stat.degen = degen_r;
  assign norm       = norm_r;

endmodule

/* src/tfn_merge.sv */
// Result buffer: collects the four lane results and sends them out one face per cycle while the output is ready.
module tfn_merge import tfn_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [NORMAL_FRAC_BITS+1:0] lane_norm [FACES][3],
  input  lane_stat_t                  lane_stat [FACES],
  input  logic                        item_end,
  output logic                        full,
  tfn_out_if.source                   out_ch
);

  localparam int OW = NORMAL_FRAC_BITS + 2;

  logic [OW-1:0] nrm_r [FACES][3];
  logic [FACES-1:0] dg_r;
  logic end_r;
  logic [1:0] cnt_r;
  logic full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      full_r <= 1'b1;
      cnt_r  <= '0;
    end else if (full_r && out_ch.ready) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'(FACES - 1)) full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nrm_r <= lane_norm;
      end_r <= item_end;
      for (int f = 0; f < FACES; f++) dg_r[f] <= lane_stat[f].degen;
    end
  end

  assign full              = full_r;
  assign out_ch.valid      = full_r;
  assign out_ch.face_index = cnt_r;
  assign out_ch.normal_x   = nrm_r[cnt_r][0];
  assign out_ch.normal_y   = nrm_r[cnt_r][1];
  assign out_ch.normal_z   = nrm_r[cnt_r][2];
  assign out_ch.degenerate = dg_r[cnt_r];
  assign out_ch.last_face  = (cnt_r == 2'(FACES - 1));
  assign out_ch.batch_end  = end_r && (cnt_r == 2'(FACES - 1));

endmodule

/* src/tetrahedron_face_normals_core.sv */
// Tetrahedron face unit normals, top level: batch counter, edge setup, four face lanes, merge.
// Each accepted tetrahedron is split into four faces that run side by side in four lanes. A lane
// forms the cross product on its shared 32x32 multiplier, normalizes the magnitudes, forms the
// sum of squares on the same multiplier, then runs the bit-serial square root and the three
// parallel dividers; a degenerate face finishes after normalization. A new tetrahedron is
// accepted only when all four lanes are idle. The four results leave from a buffer one face per
// cycle while the output is ready, in face order; meanwhile the next tetrahedron can already be
// in the lanes. The element count register can be written at any time the block is idle; cfg
// ready is always high.
module tetrahedron_face_normals_core import tfn_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tfn_in_if.sink     in_ch,
  tfn_out_if.source  out_ch,
  tfn_cfg_if.sink    cfg_ch
);

  localparam int DW = COORD_BITS + 1;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] done_r;
  logic [CNT_W-1:0] done_inc;
  logic             item_end_r;
  logic             in_acc;
  logic             all_idle;
  logic             all_done;
  logic             load;
  logic             merge_full;

  logic signed [DW-1:0] vtx [4][3];
  logic signed [DW-1:0] edge_a [FACES][3];
  logic signed [DW-1:0] edge_b [FACES][3];
  lane_stat_t                  lane_stat [FACES];
  logic [NORMAL_FRAC_BITS+1:0] lane_norm [FACES][3];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
    end else if (cfg_ch.valid) begin
      count_r <= cfg_ch.element_count;
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign done_inc = done_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r     <= '0;
      item_end_r <= 1'b0;
    end else if (in_acc) begin
      done_r     <= (done_inc == count_r) ? '0 : done_inc;
      item_end_r <= (done_inc == count_r);
    end
  end

  always_comb begin
    vtx[0][0] = DW'(in_ch.node0_x);
    vtx[0][1] = DW'(in_ch.node0_y);
    vtx[0][2] = DW'(in_ch.node0_z);
    vtx[1][0] = DW'(in_ch.node1_x);
    vtx[1][1] = DW'(in_ch.node1_y);
    vtx[1][2] = DW'(in_ch.node1_z);
    vtx[2][0] = DW'(in_ch.node2_x);
    vtx[2][1] = DW'(in_ch.node2_y);
    vtx[2][2] = DW'(in_ch.node2_z);
    vtx[3][0] = DW'(in_ch.node3_x);
    vtx[3][1] = DW'(in_ch.node3_y);
    vtx[3][2] = DW'(in_ch.node3_z);
    for (int f = 0; f < FACES; f++) begin
      for (int j = 0; j < 3; j++) begin
        edge_a[f][j] = vtx[EA0[f]][j] - vtx[EA1[f]][j];
        edge_b[f][j] = vtx[EB0[f]][j] - vtx[EB1[f]][j];
      end
    end
  end

  always_comb begin
    all_idle = 1'b1;
    all_done = 1'b1;
    for (int f = 0; f < FACES; f++) begin
      all_idle = all_idle & lane_stat[f].idle;
      all_done = all_done & lane_stat[f].done;
    end
  end

  assign in_ch.ready = all_idle;
  assign load        = all_done && !merge_full;

  for (genvar f = 0; f < FACES; f++) begin : g_lane
    tfn_lane #(
      .COORD_BITS      (COORD_BITS),
      .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (in_acc),
      .ack   (load),
      .edge_a(edge_a[f]),
      .edge_b(edge_b[f]),
      .stat  (lane_stat[f]),
      .norm  (lane_norm[f])
    );
  end

  tfn_merge #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .lane_norm(lane_norm),
    .lane_stat(lane_stat),
    .item_end (item_end_r),
    .full     (merge_full),
    .out_ch   (out_ch)
  );

endmodule

/* sim/tb_tetrahedron_face_normals_core.sv */
// Testbench for the tetrahedron face normal block: driver, monitor and face normal predictor.
`timescale 1ns / 1ps
module tb_tetrahedron_face_normals_core;
  import tfn_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int NW = FB + 2;
  localparam int WATCH_LIMIT = 40000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t n0x, n0y, n0z, n1x, n1y, n1z, n2x, n2y, n2z, n3x, n3y, n3z;
  } tet_t;
  typedef struct packed {
    logic [1:0] face;
    logic [NW-1:0] nx, ny, nz;
    logic degen, last, bend;
  } face_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  tfn_in_if  #(.COORD_BITS(CB)) in_ch ();
  tfn_out_if #(.NORMAL_FRAC_BITS(FB)) out_ch ();
  tfn_cfg_if cfg_ch ();

  tetrahedron_face_normals_core #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  tet_t tet_pending[$];
  face_res_t faces_expected[$];
  logic [CNT_W-1:0] batch_len = 1;
  logic [CNT_W-1:0] tets_in_batch = 0;
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int recv_hold = 0;
  int quiet_cycles = 0;
  bit cfg_busy = 0;
  bit in_taken = 0;
  logic [CNT_W-1:0] cfg_value;

  task automatic report(string what, logic [127:0] got, logic [127:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [NW-1:0] unit_component(logic [127:0] m, logic [127:0] len);
    logic [127:0] num, q;
    num = (m << (FB + 1)) + len;
    q = num / (len << 1);
    return q[NW-1:0];
  endfunction

  function automatic void face_normal(input logic signed [63:0] a[3], input logic signed [63:0] b[3],
                                      output logic [NW-1:0] n[3], output logic degen);
    logic signed [127:0] c[3];
    logic [127:0] mag[3], sum, len, rem, bitv, t;
    logic neg[3];
    int top, i, j;
    c[0] = 128'(a[2]) * 128'(b[1]) - 128'(a[1]) * 128'(b[2]);
    c[1] = 128'(a[0]) * 128'(b[2]) - 128'(a[2]) * 128'(b[0]);
    c[2] = 128'(a[1]) * 128'(b[0]) - 128'(a[0]) * 128'(b[1]);
    top = -1;
    for (i = 0; i < 3; i++) begin
      neg[i] = c[i][127];
      mag[i] = neg[i] ? -c[i] : c[i];
      for (j = 0; j < 128; j++) if (mag[i][j] && j > top) top = j;
    end
    degen = (top < 0);
    n[0] = '0; n[1] = '0; n[2] = '0;
    if (degen) return;
    sum = 0;
    for (i = 0; i < 3; i++) begin
      mag[i] = (top > NORM_TOP) ? mag[i] >> (top - NORM_TOP) : mag[i] << (NORM_TOP - top);
      sum += mag[i] * mag[i];
    end
    len = 0; rem = sum; bitv = 128'd1 << 126;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      t = len + bitv;
      if (rem >= t) begin
        rem -= t; len = (len >> 1) + bitv;
      end else len >>= 1;
      bitv >>= 2;
    end
    for (i = 0; i < 3; i++) begin
      n[i] = unit_component(mag[i], len);
      if (neg[i]) n[i] = -n[i];
    end
  endfunction

  task automatic predict_faces(tet_t t);
    logic signed [63:0] v[4][3], a[3], b[3];
    logic [NW-1:0] n[3];
    logic dg, bend;
    logic [CNT_W-1:0] nxt;
    face_res_t r;
    int f, j;
    v[0] = '{t.n0x, t.n0y, t.n0z}; v[1] = '{t.n1x, t.n1y, t.n1z};
    v[2] = '{t.n2x, t.n2y, t.n2z}; v[3] = '{t.n3x, t.n3y, t.n3z};
    nxt = tets_in_batch + 1'b1;
    bend = (nxt == batch_len);
    tets_in_batch = bend ? '0 : nxt;
    for (f = 0; f < FACES; f++) begin
      for (j = 0; j < 3; j++) begin
        a[j] = v[EA0[f]][j] - v[EA1[f]][j];
        b[j] = v[EB0[f]][j] - v[EB1[f]][j];
      end
      face_normal(a, b, n, dg);
      r.face = f[1:0]; r.nx = n[0]; r.ny = n[1]; r.nz = n[2];
      r.degen = dg; r.last = (f == 3); r.bend = (f == 3) && bend;
      faces_expected.push_back(r);
    end
  endtask

  always @(posedge clk) in_taken <= in_ch.valid && in_ch.ready;

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
    end else if (tet_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      {in_ch.node0_x, in_ch.node0_y, in_ch.node0_z, in_ch.node1_x, in_ch.node1_y, in_ch.node1_z,
       in_ch.node2_x, in_ch.node2_y, in_ch.node2_z, in_ch.node3_x, in_ch.node3_y,
       in_ch.node3_z} <= tet_pending.pop_front();
      in_ch.valid <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    cfg_ch.valid <= cfg_busy;
    cfg_ch.element_count <= cfg_value;
  end

  // monitor and predictor hook
  always @(posedge clk) begin
    face_res_t g, w;
    bit act;
    act = 1'b0;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        batch_len = cfg_ch.element_count;
        cfg_busy <= 1'b0;
        act = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_faces({in_ch.node0_x, in_ch.node0_y, in_ch.node0_z, in_ch.node1_x,
                       in_ch.node1_y, in_ch.node1_z, in_ch.node2_x, in_ch.node2_y,
                       in_ch.node2_z, in_ch.node3_x, in_ch.node3_y, in_ch.node3_z});
        act = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        act = 1'b1;
        g = '{out_ch.face_index, out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
              out_ch.degenerate, out_ch.last_face, out_ch.batch_end};
        if (faces_expected.size() == 0) report("unexpected face", g, 0);
        else begin
          w = faces_expected.pop_front();
          if (g.face !== w.face) report("face_index", g.face, w.face);
          if (g.nx !== w.nx) report("normal_x", g.nx, w.nx);
          if (g.ny !== w.ny) report("normal_y", g.ny, w.ny);
          if (g.nz !== w.nz) report("normal_z", g.nz, w.nz);
          if (g.degen !== w.degen) report("degenerate", g.degen, w.degen);
          if (g.last !== w.last) report("last_face", g.last, w.last);
          if (g.bend !== w.bend) report("batch_end", g.bend, w.bend);
        end
      end
      quiet_cycles <= act ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
      default: return coord_t'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
    endcase
  endfunction

  function automatic tet_t rnd_tet();
    tet_t t;
    int mode, k;
    coord_t c[12];
    mode = $urandom_range(2);
    for (k = 0; k < 12; k++) c[k] = rnd_coord(mode);
    case ($urandom_range(9))
      0: begin c[6] = c[0]; c[7] = c[1]; c[8] = c[2]; end
      1: for (k = 3; k < 6; k++) c[k + 3] = c[k] + (c[k] - c[k - 3]);
      default: ;
    endcase
    t = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
    return t;
  endfunction

  task automatic wait_drained();
    while (tet_pending.size() > 0 || faces_expected.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_value = v;
    cfg_busy = 1'b1;
    while (cfg_busy) @(posedge clk);
  endtask

  localparam coord_t CMAX = 32'sh7FFFFFFF;
  localparam coord_t CMIN = 32'sh80000000;
  localparam coord_t ONE = 32'sh00010000;

  initial begin
    int i;
    cfg_ch.valid = 1'b0;
    cfg_ch.element_count = '0;
    cfg_value = '0;
    in_ch.valid = 1'b0;
    {in_ch.node0_x, in_ch.node0_y, in_ch.node0_z, in_ch.node1_x, in_ch.node1_y, in_ch.node1_z,
     in_ch.node2_x, in_ch.node2_y, in_ch.node2_z, in_ch.node3_x, in_ch.node3_y,
     in_ch.node3_z} = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed
    send_idle_pct = 6; recv_idle_pct = 59;
    tet_pending.push_back({12{32'sd0}});
    tet_pending.push_back({32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0,
                           32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE});
    tet_pending.push_back({CMIN, CMIN, CMIN, CMAX, CMIN, CMIN,
                           CMIN, CMAX, CMIN, CMIN, CMIN, CMAX});
    tet_pending.push_back({CMAX, CMAX, CMAX, CMIN, CMAX, CMAX,
                           CMAX, CMIN, CMAX, CMAX, CMAX, CMIN});
    tet_pending.push_back({CMIN, CMAX, CMIN, CMAX, CMIN, CMAX,
                           CMIN, CMIN, CMAX, CMAX, CMAX, CMIN});
    tet_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
                           32'sd0, 32'sd1, 32'sd0, 32'sd1, 32'sd1, 32'sd0});
    tet_pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1,
                           32'sd2, 32'sd2, 32'sd2, 32'sd0, 32'sd0, 32'sd1});
    tet_pending.push_back({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0,
                           32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0, 32'sd0});
    tet_pending.push_back({32'sd0, 32'sd0, 32'sd0, -ONE, 32'sd3, 32'sd7,
                           ONE, -32'sd5, 32'sd2, 32'sd9, ONE, -ONE});
    for (i = 0; i < 6; i++) tet_pending.push_back(rnd_tet());
    wait_drained();

    write_count(16'd3);
    for (i = 0; i < 100; i++) tet_pending.push_back(rnd_tet());
    recv_hold = 3000;
    wait_drained();

    write_count(16'hFFFF);
    send_idle_pct = 59; recv_idle_pct = 6;
    for (i = 0; i < 60; i++) tet_pending.push_back(rnd_tet());
    wait_drained();

    // lowered below the running count: wraps all the way round
    write_count(16'd1);
    for (i = 0; i < 20; i++) tet_pending.push_back(rnd_tet());
    wait_drained();

    write_count(16'd0);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (i = 0; i < 60; i++) tet_pending.push_back(rnd_tet());
    wait_drained();

    write_count(16'd5);
    for (i = 0; i < 55; i++) tet_pending.push_back(rnd_tet());
    wait_drained();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

/* filelist.f */
src/tfn_pkg.sv
src/tfn_if.sv
src/tfn_lane.sv
src/tfn_merge.sv
src/tetrahedron_face_normals_core.sv
sim/tb_tetrahedron_face_normals_core.sv
